### rtl/bed_pkg.sv
// ----------------------------------------------------------------------------
// bed_pkg
// Shared types, character codes and lookup functions for the backslash
// escape decoder.
// ----------------------------------------------------------------------------
package bed_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_C         = 8'h63;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   // One queue entry holds every result that a single input byte causes.
   // The second result, when present, is always a plain data byte.
   typedef struct packed {
      logic [7:0] first_byte;
      logic       first_has;
      logic       first_stop;
      logic [7:0] second_byte;
      logic       has_second;
   } bed_entry_type;

   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] b;
      begin
         unique case (c)
            8'h61:   b = 8'h07;  // a
            8'h62:   b = 8'h08;  // b
            8'h66:   b = 8'h0C;  // f
            8'h6E:   b = 8'h0A;  // n
            8'h72:   b = 8'h0D;  // r
            8'h74:   b = 8'h09;  // t
            8'h76:   b = 8'h0B;  // v
            default: b = c;
         endcase
         return b;
      end
   endfunction

   // Returns {valid, nibble} for an ASCII hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      begin
         r = 5'b0;
         if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
         end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
         end
         return r;
      end
   endfunction

endpackage

### rtl/bed_front.sv
// ----------------------------------------------------------------------------
// bed_front
// Accepts input bytes, tracks the escape state and classifies each byte into
// a queue entry of zero, one or two results.
// ----------------------------------------------------------------------------
module bed_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cfg_we,
   input  logic                   cfg_stop_enable,
   input  logic                   req_valid,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_byte,
   output logic                   req_stall,
   input  logic                   queue_full,
   output logic                   push,
   output bed_pkg::bed_entry_type push_entry
);

   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_ESC  = 5'b00010,
      MODE_OCT  = 5'b00100,
      MODE_HEX  = 5'b01000,
      MODE_STOP = 5'b10000
   } bed_mode_type;

   bed_mode_type mode_ff, mode_in;
   logic [8:0]   acc_ff, acc_in;
   logic [1:0]   count_ff, count_in;
   logic         stop_enable_ff, stop_enable_in;

   logic         accept;
   logic         is_bsl;
   logic         idle_emit;
   logic         is_oct;
   logic [4:0]   hex;
   logic [8:0]   oct_acc;
   logic [7:0]   hex_acc;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   assign is_bsl    = (req_data_byte == bed_pkg::CHAR_BACKSLASH);
   assign idle_emit = !(is_bsl && !req_last_byte);
   assign is_oct    = (req_data_byte >= bed_pkg::CHAR_ZERO) &&
                      (req_data_byte <= bed_pkg::CHAR_SEVEN);
   assign hex       = bed_pkg::hex_digit(req_data_byte);
   assign oct_acc   = {acc_ff[5:0], req_data_byte[2:0]};
   assign hex_acc   = {acc_ff[3:0], hex[3:0]};

   assign stop_enable_in = cfg_we ? cfg_stop_enable : stop_enable_ff;

   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      push       = 1'b0;
      push_entry = '{first_byte: 8'h00, first_has: 1'b1, first_stop: 1'b0,
                     second_byte: req_data_byte, has_second: 1'b0};
      if (accept) begin
         unique case (mode_ff)
            MODE_ESC: begin
               mode_in  = MODE_IDLE;
               acc_in   = '0;
               count_in = '0;
               priority if (req_data_byte == bed_pkg::CHAR_C && stop_enable_ff) begin
                  mode_in               = MODE_STOP;
                  push                  = 1'b1;
                  push_entry.first_has  = 1'b0;
                  push_entry.first_stop = 1'b1;
               end else if (req_data_byte == bed_pkg::CHAR_ZERO && !req_last_byte) begin
                  mode_in = MODE_OCT;
               end else if (req_data_byte == bed_pkg::CHAR_X && !req_last_byte) begin
                  mode_in = MODE_HEX;
               end else begin
                  push                  = 1'b1;
                  push_entry.first_byte = (req_data_byte == bed_pkg::CHAR_ZERO) ?
                                          bed_pkg::CHAR_NUL :
                                          bed_pkg::escape_map(req_data_byte);
               end
            end
            MODE_OCT: begin
               if (is_oct) begin
                  if (count_ff == 2'd2 || req_last_byte) begin
                     push                  = 1'b1;
                     push_entry.first_byte = oct_acc[7:0];
                     mode_in               = MODE_IDLE;
                     acc_in                = '0;
                     count_in              = '0;
                  end else begin
                     acc_in   = oct_acc;
                     count_in = count_ff + 2'd1;
                  end
               end else begin
                  // The pending value goes out first, then the byte itself.
                  push                  = 1'b1;
                  push_entry.first_byte = acc_ff[7:0];
                  push_entry.has_second = idle_emit;
                  acc_in                = '0;
                  count_in              = '0;
                  mode_in               = idle_emit ? MODE_IDLE : MODE_ESC;
               end
            end
            MODE_HEX: begin
               if (hex[4]) begin
                  if (req_last_byte) begin
                     push                  = 1'b1;
                     push_entry.first_byte = hex_acc;
                     mode_in               = MODE_IDLE;
                     acc_in                = '0;
                     count_in              = '0;
                  end else begin
                     acc_in   = {1'b0, hex_acc};
                     count_in = 2'd1;
                  end
               end else begin
                  push                  = 1'b1;
                  push_entry.first_byte = (count_ff != 2'd0) ? acc_ff[7:0] : bed_pkg::CHAR_X;
                  push_entry.has_second = idle_emit;
                  acc_in                = '0;
                  count_in              = '0;
                  mode_in               = idle_emit ? MODE_IDLE : MODE_ESC;
               end
            end
            MODE_STOP: begin
               mode_in = MODE_STOP;
            end
            default: begin
               push                  = idle_emit;
               push_entry.first_byte = req_data_byte;
               mode_in               = idle_emit ? MODE_IDLE : MODE_ESC;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         acc_ff         <= '0;
         count_ff       <= '0;
         stop_enable_ff <= 1'b1;
      end else begin
         mode_ff        <= mode_in;
         acc_ff         <= acc_in;
         count_ff       <= count_in;
         stop_enable_ff <= stop_enable_in;
      end
   end

   // Once stopped, the decoder stays stopped until reset.
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_STOP |=> mode_ff == MODE_STOP)
      else $error("decoder left the stopped mode");

   // A stop result never carries a data byte or a second result.
   a_stop_entry: assert property (@(posedge clock) disable iff (reset)
      push && push_entry.first_stop |-> !push_entry.first_has && !push_entry.has_second)
      else $error("stop entry carries data");

endmodule

### rtl/bed_queue.sv
// ----------------------------------------------------------------------------
// bed_queue
// Small FIFO of classified entries between the front and back sections.
// ----------------------------------------------------------------------------
module bed_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bed_pkg::bed_entry_type push_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output bed_pkg::bed_entry_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bed_pkg::bed_entry_type store_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

### rtl/bed_back.sv
// ----------------------------------------------------------------------------
// bed_back
// Takes queue entries and sends their results out one per cycle while rsp_stall is
// low, through a registered result stage.
// ----------------------------------------------------------------------------
module bed_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bed_pkg::bed_entry_type head,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_decoded_byte,
   output logic                   rsp_has_byte,
   output logic                   rsp_stop_seen,
   output logic                   rsp_run_last
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic       stop_ff, stop_in;
   logic       last_ff, last_in;
   logic       load;

   // The result register can take a new result when it is empty or being taken.
   assign load = !empty && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      phase_in = phase_ff;
      byte_in  = byte_ff;
      has_in   = has_ff;
      stop_in  = stop_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (phase_ff) begin
            byte_in  = head.second_byte;
            has_in   = 1'b1;
            stop_in  = 1'b0;
            last_in  = 1'b1;
            pop      = 1'b1;
            phase_in = 1'b0;
         end else begin
            byte_in  = head.first_byte;
            has_in   = head.first_has;
            stop_in  = head.first_stop;
            last_in  = !head.has_second;
            pop      = !head.has_second;
            phase_in = head.has_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      has_ff  <= has_in;
      stop_ff <= stop_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_decoded_byte = byte_ff;
   assign rsp_has_byte     = has_ff;
   assign rsp_stop_seen    = stop_ff;
   assign rsp_run_last     = last_ff;

   // While the second half of an entry is owed, that entry stays at the head.
   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> !empty && head.has_second)
      else $error("second result owed without a two-result entry");

   // The second result of an entry is always the final one of its byte.
   a_phase_last: assert property (@(posedge clock) disable iff (reset)
      load && phase_ff |=> rsp_valid && rsp_run_last && rsp_has_byte)
      else $error("second result not marked final");

endmodule

### rtl/backslash_escape_decoder.sv
// ----------------------------------------------------------------------------
// backslash_escape_decoder
// Decodes a byte string with backslash escapes into plain bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one string byte per transfer, with req_last_byte
//   on the final byte. The rsp_ channel gives zero, one or two results per
//   input byte; rsp_run_last marks the final result caused by a byte. The
//   csr_ channel writes the stop enable; csr_ready is always high. Writes are
//   to be made only while the decoder is idle; the block does not enforce this.
//   A byte is classified in the cycle it is accepted and placed in a queue;
//   its results pass from the queue through the result register to rsp_.
//   Throughput is one input byte per cycle while req_stall is low. A byte
//   that ends an octal or hex run and is itself emitted yields two results
//   and occupies the result register for both; the queue absorbs the difference.
//   When the receiver stalls, the result register holds and the queue fills;
//   req_stall rises once the queue is full.
//   Reset is synchronous: it empties the queue, drops rsp_valid, returns the
//   decoder to its idle mode and sets the stop enable to 1. After a stop
//   escape every later byte is taken and dropped until reset.
// ----------------------------------------------------------------------------
module backslash_escape_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_stop_enable,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_decoded_byte,
   output logic       rsp_has_byte,
   output logic       rsp_stop_seen,
   output logic       rsp_run_last
);

   logic                   push;
   logic                   pop;
   logic                   queue_full;
   logic                   queue_empty;
   bed_pkg::bed_entry_type push_entry;
   bed_pkg::bed_entry_type head;

   assign csr_ready = 1'b1;

   bed_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg_we          (csr_valid && csr_ready),
      .cfg_stop_enable (csr_stop_enable),
      .req_valid       (req_valid),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .req_stall       (req_stall),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   bed_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   bed_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_stop_seen    (rsp_stop_seen),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

### dv/tb_backslash_escape_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_backslash_escape_decoder
// Self-checking bench for the backslash escape decoder. An in-bench predictor
// tracks the escape state of the string stream and builds the expected
// results for every accepted byte. A monitor compares each result transfer
// with the oldest expected one. Stimulus is a directed set of escapes,
// followed by random strings built from plain bytes, escapes, octal and hex
// runs and lone backslashes. Runs use random sender and receiver stalls or none,
// both settings of the stop enable, and end with a stop escape.
// ----------------------------------------------------------------------------
module tb_backslash_escape_decoder;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 40;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_ESCAPE  = 3'd1,
      ST_OCTAL   = 3'd2,
      ST_HEX     = 3'd3,
      ST_STOPPED = 3'd4
   } esc_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } string_byte_type;

   typedef struct packed {
      logic [7:0] value;
      logic       has;
      logic       stop;
      logic       last;
   } decoded_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       csr_valid       = 1'b0;
   logic       csr_ready;
   logic       csr_stop_enable = 1'b0;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte   = 8'h00;
   logic       req_last_byte   = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_decoded_byte;
   logic       rsp_has_byte;
   logic       rsp_stop_seen;
   logic       rsp_run_last;

   // Predictor state.
   esc_mode_type mode_q       = ST_IDLE;
   logic [8:0]   acc_q        = '0;
   logic [1:0]   digits_q     = '0;
   logic         stop_enabled = 1'b1;

   string_byte_type pending_bytes[$];
   decoded_type     decoded_q[$];

   int    mismatch_count = 0;
   int    quiet_cycles   = 0;
   int    idle_mode      = 0;
   int    hold_left      = 0;
   bit    hold_request   = 0;
   bit    req_taken      = 0;
   string escape_letters = "abfnrtvc\\q?\"";
   string hex_letters    = "0123456789abcdefABCDEF";

   backslash_escape_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_stop_enable  (csr_stop_enable),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decoded_byte (rsp_decoded_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_stop_seen    (rsp_stop_seen),
      .rsp_run_last     (rsp_run_last)
   );

   always #6 clock = ~clock;

   function automatic int hex_value(input logic [7:0] c);
      if (c >= bed_pkg::CHAR_ZERO && c <= "9") return int'(c) - int'(bed_pkg::CHAR_ZERO);
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic decoded_type data_result(input logic [7:0] b);
      return '{value: b, has: 1'b1, stop: 1'b0, last: 1'b0};
   endfunction

   task automatic clear_run();
      mode_q   = ST_IDLE;
      acc_q    = '0;
      digits_q = '0;
   endtask

   // Works out the results that one accepted byte causes and queues them.
   task automatic decode_byte(input logic [7:0] c, input logic last);
      decoded_type res [2];
      int          n;
      int          nib;
      bit          plain_pass;
      bit          give;
      logic [7:0]  b;
      n          = 0;
      plain_pass = 0;
      nib        = hex_value(c);
      case (mode_q)
         ST_STOPPED: ;
         ST_ESCAPE: begin
            clear_run();
            b    = c;
            give = 1;
            case (c)
               "a": b = 8'h07;
               "b": b = 8'h08;
               "f": b = 8'h0C;
               "n": b = 8'h0A;
               "r": b = 8'h0D;
               "t": b = 8'h09;
               "v": b = 8'h0B;
               bed_pkg::CHAR_C: begin
                  if (stop_enabled) begin
                     mode_q = ST_STOPPED;
                     res[n] = '{value: bed_pkg::CHAR_NUL, has: 1'b0, stop: 1'b1,
                                last: 1'b0};
                     n++;
                     give = 0;
                  end
               end
               bed_pkg::CHAR_ZERO: begin
                  if (last) begin
                     b = bed_pkg::CHAR_NUL;
                  end else begin
                     mode_q = ST_OCTAL;
                     give   = 0;
                  end
               end
               bed_pkg::CHAR_X: begin
                  if (!last) begin
                     mode_q = ST_HEX;
                     give   = 0;
                  end
               end
               default: ;
            endcase
            if (give) begin
               res[n] = data_result(b);
               n++;
            end
         end
         ST_OCTAL: begin
            if (c >= bed_pkg::CHAR_ZERO && c <= bed_pkg::CHAR_SEVEN && digits_q < 2'd3) begin
               acc_q    = {acc_q[5:0], c[2:0]};
               digits_q = digits_q + 2'd1;
               if (digits_q == 2'd3 || last) begin
                  res[n] = data_result(acc_q[7:0]);
                  n++;
                  clear_run();
               end
            end else begin
               res[n] = data_result(acc_q[7:0]);
               n++;
               clear_run();
               plain_pass = 1;
            end
         end
         ST_HEX: begin
            if (nib >= 0) begin
               acc_q    = {1'b0, acc_q[3:0], 4'(nib)};
               digits_q = 2'd1;
               if (last) begin
                  res[n] = data_result(acc_q[7:0]);
                  n++;
                  clear_run();
               end
            end else begin
               // A bare \x with no digits stands for the letter itself.
               res[n] = data_result(digits_q != 2'd0 ? acc_q[7:0] : bed_pkg::CHAR_X);
               n++;
               clear_run();
               plain_pass = 1;
            end
         end
         default: plain_pass = 1;
      endcase
      if (plain_pass) begin
         if (c == bed_pkg::CHAR_BACKSLASH) begin
            if (last) begin
               res[n] = data_result(bed_pkg::CHAR_BACKSLASH);
               n++;
            end else begin
               mode_q = ST_ESCAPE;
            end
         end else begin
            res[n] = data_result(c);
            n++;
         end
      end
      if (n > 0) res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
   endtask

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
   endtask

   task automatic queue_item(input logic [7:0] data, input logic last);
      pending_bytes.push_back('{data: data, last: last});
   endtask

   task automatic queue_text(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++) queue_item(s[i], ends && i == s.len() - 1);
   endtask

   // Random strings made mostly of well-formed escapes and numeric runs, with
   // plain bytes and lone backslashes mixed in. Without with_c the byte 'c'
   // never appears, so a stop cannot end the run early.
   task automatic queue_random_strings(input int target, input bit with_c);
      logic [7:0] text[$];
      int         added;
      int         tokens;
      int         pick;
      logic [7:0] b;
      added = 0;
      while (added < target) begin
         text.delete();
         tokens = $urandom_range(6, 1);
         for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               text.push_back(8'($urandom_range(255)));
            end else if (pick < 50) begin
               text.push_back(bed_pkg::CHAR_BACKSLASH);
               text.push_back(escape_letters[$urandom_range(escape_letters.len() - 1)]);
            end else if (pick < 70) begin
               text.push_back(bed_pkg::CHAR_BACKSLASH);
               text.push_back(bed_pkg::CHAR_ZERO);
               repeat ($urandom_range(4))
                  text.push_back(bed_pkg::CHAR_ZERO + 8'($urandom_range(7)));
            end else if (pick < 90) begin
               text.push_back(bed_pkg::CHAR_BACKSLASH);
               text.push_back(bed_pkg::CHAR_X);
               repeat ($urandom_range(4))
                  text.push_back(hex_letters[$urandom_range(hex_letters.len() - 1)]);
            end else begin
               text.push_back(bed_pkg::CHAR_BACKSLASH);
            end
         end
         for (int i = 0; i < text.size(); i++) begin
            b = text[i];
            if (!with_c && b == bed_pkg::CHAR_C) b = "d";
            queue_item(b, i == text.size() - 1);
         end
         added += text.size();
      end
   endtask

   task automatic wait_until_drained();
      while (pending_bytes.size() != 0 || req_valid || decoded_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_stop_enable(input logic value);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_stop_enable <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Byte sender.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_bytes.size() != 0 &&
             !(idle_mode != 2 && $urandom_range(99) < (idle_mode == 0 ? 33 : 45))) begin
            req_valid     <= 1'b1;
            req_data_byte <= pending_bytes[0].data;
            req_last_byte <= pending_bytes[0].last;
            void'(pending_bytes.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver, with an occasional long hold-off to fill the block.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (idle_mode != 2) &&
                      ($urandom_range(99) < (idle_mode == 0 ? 45 : 33));
      end
   end

   // Monitor: register writes, byte transfers into the predictor, and result
   // transfers against the expected results.
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      req_taken = 0;
      if (!reset) begin
         if (csr_valid && csr_ready) stop_enabled = csr_stop_enable;
         if (req_valid && !req_stall) begin
            req_taken = 1;
            decode_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{value: rsp_decoded_byte, has: rsp_has_byte,
                    stop: rsp_stop_seen, last: rsp_run_last};
            if (decoded_q.size() == 0) begin
               note_failure($sformatf("unexpected result byte=%02h has=%b stop=%b last=%b",
                                      got.value, got.has, got.stop, got.last));
            end else begin
               want = decoded_q.pop_front();
               if (got.value !== want.value || got.has !== want.has ||
                   got.stop !== want.stop || got.last !== want.last)
                  note_failure($sformatf({"result mismatch: expected byte=%02h ",
                                          "has=%b stop=%b last=%b, got byte=%02h ",
                                          "has=%b stop=%b last=%b"},
                                         want.value, want.has, want.stop, want.last,
                                         got.value, got.has, got.stop, got.last));
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // Directed part, with the stop enable at its reset value.
      queue_item(bed_pkg::CHAR_NUL, 1'b0);
      queue_item(8'hFF, 1'b0);
      queue_text("\\a\\t\\\\", 0);
      queue_text("\\0777", 0);   // third digit ends the run; value wraps to 8 bits
      queue_text("\\x4G", 0);    // hex value and the ending byte in one transfer
      queue_text("\\xq", 0);     // bare \x followed by a plain byte
      queue_text("\\05", 1);     // octal run cut short by the last byte
      queue_text("\\x", 1);
      queue_text("\\0", 1);
      queue_text("\\", 1);       // trailing lone backslash
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_until_drained();

      write_stop_enable(1'b0);
      queue_text("\\c", 0);
      queue_random_strings(140, 1);
      @(posedge clock);
      hold_request = 1;
      wait_until_drained();

      idle_mode = 1;
      write_stop_enable(1'b1);
      queue_random_strings(130, 0);
      wait_until_drained();

      idle_mode = 2;
      write_stop_enable(1'b0);
      queue_random_strings(130, 1);
      @(posedge clock);
      hold_request = 1;
      wait_until_drained();

      // Stop escape: everything after it, across strings, is dropped.
      write_stop_enable(1'b1);
      queue_text("A\\cB", 1);
      queue_text("\\n7", 1);
      wait_until_drained();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
